// File: hdl/ksd_pkg.sv
`default_nettype none

package ksd_pkg;

  // Scancode bytes with a fixed meaning
  localparam logic [7:0] SC_PREFIX     = 8'hE0;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_CTRL       = 8'h1D;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
  localparam int unsigned SC_BREAK_BIT = 7;

  // Extended make codes that have a configurable character
  localparam logic [7:0] SC_EXT_UP     = 8'h48;
  localparam logic [7:0] SC_EXT_DOWN   = 8'h50;
  localparam logic [7:0] SC_EXT_LEFT   = 8'h4B;
  localparam logic [7:0] SC_EXT_RIGHT  = 8'h4D;
  localparam logic [7:0] SC_EXT_DELETE = 8'h53;
  localparam logic [7:0] SC_EXT_PGUP   = 8'h49;
  localparam logic [7:0] SC_EXT_PGDN   = 8'h51;

  // Ctrl turns a letter into its control code
  localparam logic [7:0] CTRL_MASK = 8'h1F;

  localparam int unsigned NUM_CODES = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CHAR_W    = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARROW_UP    = 3'd0,
    CFG_ARROW_DOWN  = 3'd1,
    CFG_ARROW_LEFT  = 3'd2,
    CFG_ARROW_RIGHT = 3'd3,
    CFG_DELETE      = 3'd4,
    CFG_PAGE_UP     = 3'd5,
    CFG_PAGE_DOWN   = 3'd6
  } cfg_reg_e;

  localparam logic [CHAR_W-1:0] CFG_RESET [NUM_CODES] =
    '{8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134};

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_kind_e;

  // One operation handed from the decoder to the character FIFO
  typedef struct packed {
    op_kind_e          kind;
    logic [CHAR_W-1:0] ch;
  } op_t;

  // Unshifted key map, codes past the keypad map to zero
  function automatic logic [CHAR_W-1:0] plain_map(input logic [6:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      7'd1:  c = 8'h1B;  7'd2:  c = 8'h31;  7'd3:  c = 8'h32;  7'd4:  c = 8'h33;
      7'd5:  c = 8'h34;  7'd6:  c = 8'h35;  7'd7:  c = 8'h36;  7'd8:  c = 8'h37;
      7'd9:  c = 8'h38;  7'd10: c = 8'h39;  7'd11: c = 8'h30;  7'd12: c = 8'h2D;
      7'd13: c = 8'h3D;  7'd14: c = 8'h08;  7'd15: c = 8'h09;  7'd16: c = 8'h71;
      7'd17: c = 8'h77;  7'd18: c = 8'h65;  7'd19: c = 8'h72;  7'd20: c = 8'h74;
      7'd21: c = 8'h79;  7'd22: c = 8'h75;  7'd23: c = 8'h69;  7'd24: c = 8'h6F;
      7'd25: c = 8'h70;  7'd26: c = 8'h5B;  7'd27: c = 8'h5D;  7'd28: c = 8'h0A;
      7'd30: c = 8'h61;  7'd31: c = 8'h73;  7'd32: c = 8'h64;  7'd33: c = 8'h66;
      7'd34: c = 8'h67;  7'd35: c = 8'h68;  7'd36: c = 8'h6A;  7'd37: c = 8'h6B;
      7'd38: c = 8'h6C;  7'd39: c = 8'h3B;  7'd40: c = 8'h27;  7'd41: c = 8'h60;
      7'd43: c = 8'h5C;  7'd44: c = 8'h7A;  7'd45: c = 8'h78;  7'd46: c = 8'h63;
      7'd47: c = 8'h76;  7'd48: c = 8'h62;  7'd49: c = 8'h6E;  7'd50: c = 8'h6D;
      7'd51: c = 8'h2C;  7'd52: c = 8'h2E;  7'd53: c = 8'h2F;  7'd55: c = 8'h2A;
      7'd57: c = 8'h20;  7'd71: c = 8'h37;  7'd72: c = 8'h38;  7'd73: c = 8'h39;
      7'd74: c = 8'h2D;  7'd75: c = 8'h34;  7'd76: c = 8'h35;  7'd77: c = 8'h36;
      7'd78: c = 8'h2B;  7'd79: c = 8'h31;  7'd80: c = 8'h32;  7'd81: c = 8'h33;
      7'd82: c = 8'h30;  7'd83: c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Shifted key map
  function automatic logic [CHAR_W-1:0] shifted_map(input logic [6:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      7'd1:  c = 8'h1B;  7'd2:  c = 8'h21;  7'd3:  c = 8'h40;  7'd4:  c = 8'h23;
      7'd5:  c = 8'h24;  7'd6:  c = 8'h25;  7'd7:  c = 8'h5E;  7'd8:  c = 8'h26;
      7'd9:  c = 8'h2A;  7'd10: c = 8'h28;  7'd11: c = 8'h29;  7'd12: c = 8'h5F;
      7'd13: c = 8'h2B;  7'd14: c = 8'h08;  7'd15: c = 8'h09;  7'd16: c = 8'h51;
      7'd17: c = 8'h57;  7'd18: c = 8'h45;  7'd19: c = 8'h52;  7'd20: c = 8'h54;
      7'd21: c = 8'h59;  7'd22: c = 8'h55;  7'd23: c = 8'h49;  7'd24: c = 8'h4F;
      7'd25: c = 8'h50;  7'd26: c = 8'h7B;  7'd27: c = 8'h7D;  7'd28: c = 8'h0A;
      7'd30: c = 8'h41;  7'd31: c = 8'h53;  7'd32: c = 8'h44;  7'd33: c = 8'h46;
      7'd34: c = 8'h47;  7'd35: c = 8'h48;  7'd36: c = 8'h4A;  7'd37: c = 8'h4B;
      7'd38: c = 8'h4C;  7'd39: c = 8'h3A;  7'd40: c = 8'h22;  7'd41: c = 8'h7E;
      7'd43: c = 8'h7C;  7'd44: c = 8'h5A;  7'd45: c = 8'h58;  7'd46: c = 8'h43;
      7'd47: c = 8'h56;  7'd48: c = 8'h42;  7'd49: c = 8'h4E;  7'd50: c = 8'h4D;
      7'd51: c = 8'h3C;  7'd52: c = 8'h3E;  7'd53: c = 8'h3F;  7'd55: c = 8'h2A;
      7'd57: c = 8'h20;  7'd71: c = 8'h37;  7'd72: c = 8'h38;  7'd73: c = 8'h39;
      7'd74: c = 8'h2D;  7'd75: c = 8'h34;  7'd76: c = 8'h35;  7'd77: c = 8'h36;
      7'd78: c = 8'h2B;  7'd79: c = 8'h31;  7'd80: c = 8'h32;  7'd81: c = 8'h33;
      7'd82: c = 8'h30;  7'd83: c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ksd_if.sv
`default_nettype none

// Input channel: scancode words and read requests
interface ksd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] scancode;

  modport source (output valid, output action, output scancode, input ready);
  modport sink   (input valid, input action, input scancode, output ready);
endinterface

// Output channel: one word per read request
interface ksd_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_code;

  modport source (output valid, output char_valid, output char_code, input ready);
  modport sink   (input valid, input char_valid, input char_code, output ready);
endinterface

`default_nettype wire

// File: hdl/ksd_front.sv
`default_nettype none

// Decoder: tracks modifiers and the extended prefix, turns reads and character keys into ops
module ksd_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ksd_in_if.sink                             scan_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [ksd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ksd_pkg::CHAR_W-1:0]    cfg_wdata_i,
  output logic                               op_valid_o,
  output ksd_pkg::op_t                       op_o,
  input  wire logic                          op_ready_i
);

  logic [ksd_pkg::CHAR_W-1:0] code_q [ksd_pkg::NUM_CODES];
  logic shift_q, shift_d;
  logic ctrl_q, ctrl_d;
  logic prefix_q, prefix_d;
  logic accept;
  logic [7:0] sc;
  logic [ksd_pkg::CHAR_W-1:0] ch;
  logic letter;

  assign scan_i.ready = op_ready_i;
  assign accept       = scan_i.valid & op_ready_i;
  assign sc           = scan_i.scancode;

  // Configured codes for the extended keys
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ksd_pkg::NUM_CODES; i++) begin
        code_q[i] <= ksd_pkg::CFG_RESET[i];
      end
    end else if (cfg_we_i && (cfg_idx_i < ksd_pkg::CFG_IDX_W'(ksd_pkg::NUM_CODES))) begin
      code_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Table lookup with shift, then ctrl folding of letters
  always_comb begin
    ch = shift_q ? ksd_pkg::shifted_map(sc[6:0]) : ksd_pkg::plain_map(sc[6:0]);
    letter = ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
    if (ctrl_q && letter) begin
      ch = ch & ksd_pkg::CTRL_MASK;
    end
  end

  // Classify the word: flag updates and the op to hand on
  always_comb begin
    shift_d    = shift_q;
    ctrl_d     = ctrl_q;
    prefix_d   = prefix_q;
    op_valid_o = 1'b0;
    op_o.kind  = ksd_pkg::OP_PUSH;
    op_o.ch    = ch;
    if (scan_i.action) begin
      op_valid_o = scan_i.valid;
      op_o.kind  = ksd_pkg::OP_READ;
    end else if (sc == ksd_pkg::SC_PREFIX) begin
      prefix_d = 1'b1;
    end else if (prefix_q) begin
      prefix_d   = 1'b0;
      op_valid_o = scan_i.valid;
      case (sc)
        ksd_pkg::SC_EXT_UP:     op_o.ch = code_q[ksd_pkg::CFG_ARROW_UP];
        ksd_pkg::SC_EXT_DOWN:   op_o.ch = code_q[ksd_pkg::CFG_ARROW_DOWN];
        ksd_pkg::SC_EXT_LEFT:   op_o.ch = code_q[ksd_pkg::CFG_ARROW_LEFT];
        ksd_pkg::SC_EXT_RIGHT:  op_o.ch = code_q[ksd_pkg::CFG_ARROW_RIGHT];
        ksd_pkg::SC_EXT_DELETE: op_o.ch = code_q[ksd_pkg::CFG_DELETE];
        ksd_pkg::SC_EXT_PGUP:   op_o.ch = code_q[ksd_pkg::CFG_PAGE_UP];
        ksd_pkg::SC_EXT_PGDN:   op_o.ch = code_q[ksd_pkg::CFG_PAGE_DOWN];
        default:                op_valid_o = 1'b0;
      endcase
    end else if ((sc == ksd_pkg::SC_LSHIFT) || (sc == ksd_pkg::SC_RSHIFT)) begin
      shift_d = 1'b1;
    end else if (sc == ksd_pkg::SC_CTRL) begin
      ctrl_d = 1'b1;
    end else if ((sc == ksd_pkg::SC_LSHIFT_BRK) || (sc == ksd_pkg::SC_RSHIFT_BRK)) begin
      shift_d = 1'b0;
    end else if (sc == ksd_pkg::SC_CTRL_BRK) begin
      ctrl_d = 1'b0;
    end else if (!sc[ksd_pkg::SC_BREAK_BIT]) begin
      // zero entries push nothing
      op_valid_o = scan_i.valid & (ch != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      ctrl_q   <= 1'b0;
      prefix_q <= 1'b0;
    end else if (accept) begin
      shift_q  <= shift_d;
      ctrl_q   <= ctrl_d;
      prefix_q <= prefix_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ksd_opq.sv
`default_nettype none

// Two-entry op queue between decoder and character FIFO
module ksd_opq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  input  wire ksd_pkg::op_t  push_op_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output ksd_pkg::op_t       pop_op_o,
  input  wire logic          pop_ready_i
);

  ksd_pkg::op_t slot_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q, cnt_d;
  logic         push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_op_o     = slot_q[rptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ksd_back.sv
`default_nettype none

// Character ring FIFO and output register
module ksd_back #(
  parameter int unsigned FIFO_DEPTH = 128
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          op_valid_i,
  input  wire ksd_pkg::op_t  op_i,
  output logic               op_ready_o,
  ksd_out_if.source          char_o
);

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FIFO_DEPTH - 1);

  logic [ksd_pkg::CHAR_W-1:0] mem [FIFO_DEPTH];
  logic [ksd_pkg::CHAR_W-1:0] rd_data_q;
  logic [PtrW-1:0] wr_q, rd_q, wr_next, rd_next;
  logic out_valid_q, out_valid_d;
  logic char_valid_q, char_valid_d;
  logic out_free, fire, empty, mem_we, mem_re;

  assign wr_next = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
  assign rd_next = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
  assign empty   = (rd_q == wr_q);

  // a push never needs the output slot
  assign out_free   = !out_valid_q | char_o.ready;
  assign op_ready_o = (op_i.kind == ksd_pkg::OP_PUSH) | out_free;
  assign fire       = op_valid_i & op_ready_o;
  assign mem_we     = fire & (op_i.kind == ksd_pkg::OP_PUSH) & (wr_next != rd_q);
  assign mem_re     = fire & (op_i.kind == ksd_pkg::OP_READ) & !empty;

  // output word control
  always_comb begin
    out_valid_d  = out_valid_q;
    char_valid_d = char_valid_q;
    if (fire && (op_i.kind == ksd_pkg::OP_READ)) begin
      out_valid_d  = 1'b1;
      char_valid_d = !empty;
    end else if (char_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q         <= '0;
      rd_q         <= '0;
      out_valid_q  <= 1'b0;
      char_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      char_valid_q <= char_valid_d;
      if (mem_we) wr_q <= wr_next;
      if (mem_re) rd_q <= rd_next;
    end
  end

  // character store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_q] <= op_i.ch;
    if (mem_re) rd_data_q <= mem[rd_q];
  end

  assign char_o.valid      = out_valid_q;
  assign char_o.char_valid = char_valid_q;
  assign char_o.char_code  = char_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// File: hdl/keyboard_scancode_decoder_fifo_top.sv
// Set 1 keyboard scancode decoder with a character FIFO.
//
// scan_i carries words with action 0 (a raw scancode) or action 1 (a read
// request); a word is taken when valid and ready are both high. Scancodes
// update shift, ctrl and extended-prefix state and may push one character
// into a ring FIFO of FIFO_DEPTH entries (FIFO_DEPTH-1 usable, pushes to a
// full FIFO are dropped). Each read request returns exactly one word on
// char_o: char_valid and the oldest character, or 0/0 when empty.
// Scancodes produce no output word.
//
// Throughput: one word per cycle while the op queue has room. A read's
// answer reaches char_o through the op queue, then the FIFO read register.
// When char_o stalls, the output register holds and the two-entry op queue
// fills; scan_i.ready drops once that queue is full. Pushes ahead of the
// next read still drain. The cfg port writes the seven extended-key codes;
// the user must write them only while idle; the block does not enforce it.
// Reset clears modifiers, prefix, pointers and restores the default codes;
// the character store itself is not cleared and needs no clearing pass.
`default_nettype none

module keyboard_scancode_decoder_fifo_top #(
  parameter int unsigned FIFO_DEPTH = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ksd_in_if.sink                             scan_i,
  ksd_out_if.source                          char_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [ksd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ksd_pkg::CHAR_W-1:0]    cfg_wdata_i
);

  logic         dec_valid, dec_ready;
  ksd_pkg::op_t dec_op;
  logic         q_valid, q_ready;
  ksd_pkg::op_t q_op;

  ksd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_i      (scan_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_valid_o  (dec_valid),
    .op_o        (dec_op),
    .op_ready_i  (dec_ready)
  );

  ksd_opq u_opq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (dec_valid),
    .push_op_i    (dec_op),
    .push_ready_o (dec_ready),
    .pop_valid_o  (q_valid),
    .pop_op_o     (q_op),
    .pop_ready_i  (q_ready)
  );

  ksd_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (q_op),
    .op_ready_o (q_ready),
    .char_o     (char_o)
  );

endmodule

`default_nettype wire

// File: hdl/ksd_checker.sv
`default_nettype none

module ksd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       char_valid_i,
  input wire logic [7:0] char_code_i
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(char_valid_i) && $stable(char_code_i))
    else $error("output word changed while stalled");

  // empty read answers zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !char_valid_i |-> (char_code_i == 8'h00))
    else $error("empty read with nonzero code");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("output word right after reset");

  // an idle output lets the op queue drain, so input is ready
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!out_valid_i) |-> in_ready_i)
    else $error("input stalled although output was idle");

endmodule

bind keyboard_scancode_decoder_fifo_top ksd_checker u_ksd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (scan_i.ready),
  .out_valid_i  (char_o.valid),
  .out_ready_i  (char_o.ready),
  .char_valid_i (char_o.char_valid),
  .char_code_i  (char_o.char_code)
);

`default_nettype wire

// File: bench/keyboard_scancode_decoder_fifo_top_tb.sv
`timescale 1ns / 1ps

module keyboard_scancode_decoder_fifo_top_tb;

  localparam int unsigned FIFO_DEPTH   = 128;
  localparam int unsigned RUN_LIMIT_NS = 10_000_000;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam logic [ksd_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef enum logic {
    ACT_SCAN = 1'b0,
    ACT_READ = 1'b1
  } scan_action_e;

  typedef enum int {
    SET_DEFAULT,
    SET_ZERO,
    SET_FULL,
    SET_RANDOM
  } code_set_e;

  typedef struct packed {
    scan_action_e action;
    logic [7:0]   scancode;
  } scan_word_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_code;
  } char_word_t;

  // Key translation, set 1 make codes 0x00..0x53
  logic [7:0] plain_chars [84] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E
  };

  logic [7:0] shifted_chars [84] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                          cfg_we    = 1'b0;
  logic [ksd_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [ksd_pkg::CHAR_W-1:0]    cfg_wdata = '0;

  ksd_in_if  scan_if ();
  ksd_out_if char_if ();

  keyboard_scancode_decoder_fifo_top #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_i      (scan_if),
    .char_o      (char_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the decoder state
  logic [7:0] key_code [ksd_pkg::NUM_CODES];
  logic [7:0] ext_keys [ksd_pkg::NUM_CODES];
  bit         shift_q, ctrl_q, prefix_q;
  logic [7:0] char_fifo [$];

  scan_word_t pending_words [$];
  char_word_t expected_chars [$];
  int unsigned phase_items;
  int unsigned mismatch_count = 0;

  int unsigned in_gap, in_calm, out_gap, out_calm;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] key_char(input logic [6:0] key, input bit shift,
                                          input bit ctrl);
    logic [7:0] c;
    c = 8'h00;
    if (key < 84) c = shift ? shifted_chars[key] : plain_chars[key];
    if (ctrl && c >= "A" && c <= "Z") c = (c - "A" + 8'd1) & ksd_pkg::CTRL_MASK;
    else if (ctrl && c >= "a" && c <= "z") c = (c - "a" + 8'd1) & ksd_pkg::CTRL_MASK;
    return c;
  endfunction

  // Full FIFO drops the character
  task automatic push_char(input logic [7:0] ch);
    if (char_fifo.size() < FIFO_DEPTH - 1) char_fifo.push_back(ch);
  endtask

  // Advance the shadow state by one accepted word
  task automatic apply_keyboard_word(input scan_action_e action, input logic [7:0] sc);
    char_word_t res;
    if (action == ACT_READ) begin
      res.char_valid = 1'b0;
      res.char_code  = 8'h00;
      if (char_fifo.size() != 0) begin
        res.char_valid = 1'b1;
        res.char_code  = char_fifo.pop_front();
      end
      expected_chars.push_back(res);
    end else if (sc == ksd_pkg::SC_PREFIX) begin
      prefix_q = 1'b1;
    end else if (prefix_q) begin
      // any extended code besides the seven keys just clears the prefix
      prefix_q = 1'b0;
      for (int i = 0; i < ksd_pkg::NUM_CODES; i++)
        if (sc == ext_keys[i]) push_char(key_code[i]);
    end else if (sc == ksd_pkg::SC_LSHIFT || sc == ksd_pkg::SC_RSHIFT) begin
      shift_q = 1'b1;
    end else if (sc == ksd_pkg::SC_CTRL) begin
      ctrl_q = 1'b1;
    end else if (sc == ksd_pkg::SC_LSHIFT_BRK || sc == ksd_pkg::SC_RSHIFT_BRK) begin
      shift_q = 1'b0;
    end else if (sc == ksd_pkg::SC_CTRL_BRK) begin
      ctrl_q = 1'b0;
    end else if (!sc[ksd_pkg::SC_BREAK_BIT]) begin
      res.char_code = key_char(sc[6:0], shift_q, ctrl_q);
      if (res.char_code != 8'h00) push_char(res.char_code);
    end
  endtask

  // Every queued word counts toward the phase size
  task automatic queue_word(input scan_action_e act, input logic [7:0] sc);
    scan_word_t w;
    w.action   = act;
    w.scancode = sc;
    pending_words.push_back(w);
    phase_items++;
  endtask

  // Drain all outstanding work, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || scan_if.valid || expected_chars.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Write all seven key codes plus the unused index, one per cycle
  task automatic program_key_codes(input code_set_e set);
    logic [7:0] v;
    for (int i = 0; i < ksd_pkg::NUM_CODES; i++) begin
      case (set)
        SET_DEFAULT: v = ksd_pkg::CFG_RESET[i];
        SET_ZERO:    v = 8'h00;
        SET_FULL:    v = 8'hFF;
        default:     v = 8'($urandom);
      endcase
      @(posedge clk_i);
      cfg_we    <= 1'b1;
      cfg_idx   <= ksd_pkg::CFG_IDX_W'(i);
      cfg_wdata <= v;
      key_code[i] = v;
    end
    @(posedge clk_i);
    cfg_idx   <= CFG_IDX_UNUSED;
    cfg_wdata <= 8'($urandom);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random_phase(input int unsigned target, input bit with_flood);
    int unsigned pick, mods;
    logic [7:0] key;
    phase_items = 0;
    // fill past capacity, then read past empty
    if (with_flood) begin
      repeat (FIFO_DEPTH + 4) queue_word(ACT_SCAN, 8'($urandom_range(8'h10, 8'h19)));
      repeat (FIFO_DEPTH + 6) queue_word(ACT_READ, 8'($urandom));
    end
    while (phase_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // typed keys under random modifiers
        mods = $urandom_range(0, 3);
        if (mods[0])
          queue_word(ACT_SCAN,
                     $urandom_range(0, 1) ? ksd_pkg::SC_LSHIFT : ksd_pkg::SC_RSHIFT);
        if (mods[1]) queue_word(ACT_SCAN, ksd_pkg::SC_CTRL);
        repeat ($urandom_range(1, 6)) begin
          key = 8'($urandom_range(1, 8'h58));
          queue_word(ACT_SCAN, key);
          if ($urandom_range(0, 1)) queue_word(ACT_SCAN, key | 8'h80);
          if ($urandom_range(0, 2) == 0) queue_word(ACT_READ, 8'($urandom));
        end
        if (mods[0] && $urandom_range(0, 4) != 0)
          queue_word(ACT_SCAN,
                     $urandom_range(0, 1) ? ksd_pkg::SC_LSHIFT_BRK : ksd_pkg::SC_RSHIFT_BRK);
        if (mods[1] && $urandom_range(0, 4) != 0) queue_word(ACT_SCAN, ksd_pkg::SC_CTRL_BRK);
      end else if (pick < 75) begin
        // extended sequence, sometimes with a doubled prefix
        if ($urandom_range(0, 5) == 0) queue_word(ACT_SCAN, ksd_pkg::SC_PREFIX);
        queue_word(ACT_SCAN, ksd_pkg::SC_PREFIX);
        if ($urandom_range(0, 9) < 7) queue_word(ACT_SCAN, ext_keys[$urandom_range(0, 6)]);
        else queue_word(ACT_SCAN, 8'($urandom));
        if ($urandom_range(0, 1)) queue_word(ACT_READ, 8'($urandom));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) queue_word(ACT_READ, 8'($urandom));
      end else begin
        queue_word(scan_action_e'($urandom_range(0, 1)), 8'($urandom));
      end
    end
  endtask

  // Input driver; the shadow model advances on each accepted word
  always @(posedge clk_i or negedge rst_ni) begin : scan_driver
    scan_word_t w;
    if (!rst_ni) begin
      scan_if.valid    <= 1'b0;
      scan_if.action   <= ACT_SCAN;
      scan_if.scancode <= '0;
      in_gap  <= 0;
      in_calm <= 0;
    end else begin
      if (scan_if.valid && scan_if.ready)
        apply_keyboard_word(scan_action_e'(scan_if.action), scan_if.scancode);
      if (!scan_if.valid || scan_if.ready) begin
        if (in_gap != 0) begin
          scan_if.valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          scan_if.valid    <= 1'b1;
          scan_if.action   <= w.action;
          scan_if.scancode <= w.scancode;
          if (in_calm != 0) begin
            in_calm <= in_calm - 1;
            in_gap  <= 0;
          end else begin
            if ($urandom_range(0, 99) < 3) in_calm <= $urandom_range(20, 80);
            in_gap <= idle_len();
          end
        end else begin
          scan_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random backpressure
  always @(posedge clk_i or negedge rst_ni) begin : char_monitor
    char_word_t want;
    if (!rst_ni) begin
      char_if.ready <= 1'b0;
      out_gap  <= 0;
      out_calm <= 0;
    end else begin
      if (char_if.valid && char_if.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char word: expected none, got valid=%0b code=%02h",
                   $time, char_if.char_valid, char_if.char_code);
          mismatch_count++;
        end else begin
          want = expected_chars.pop_front();
          if (char_if.char_valid !== want.char_valid || char_if.char_code !== want.char_code) begin
            $display("%0t: char word mismatch: expected valid=%0b code=%02h, got valid=%0b code=%02h",
                     $time, want.char_valid, want.char_code,
                     char_if.char_valid, char_if.char_code);
            mismatch_count++;
          end
        end
      end
      if (out_gap != 0) begin
        char_if.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        char_if.ready <= 1'b1;
        if (out_calm != 0) begin
          out_calm <= out_calm - 1;
        end else begin
          if ($urandom_range(0, 99) < 2) out_calm <= $urandom_range(20, 80);
          out_gap <= ($urandom_range(0, 3) == 0) ? idle_len() : 0;
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni           = 1'b0;
    scan_if.valid    = 1'b0;
    scan_if.action   = ACT_SCAN;
    scan_if.scancode = '0;
    char_if.ready    = 1'b0;
    for (int i = 0; i < ksd_pkg::NUM_CODES; i++) key_code[i] = ksd_pkg::CFG_RESET[i];
    ext_keys[ksd_pkg::CFG_ARROW_UP]    = ksd_pkg::SC_EXT_UP;
    ext_keys[ksd_pkg::CFG_ARROW_DOWN]  = ksd_pkg::SC_EXT_DOWN;
    ext_keys[ksd_pkg::CFG_ARROW_LEFT]  = ksd_pkg::SC_EXT_LEFT;
    ext_keys[ksd_pkg::CFG_ARROW_RIGHT] = ksd_pkg::SC_EXT_RIGHT;
    ext_keys[ksd_pkg::CFG_DELETE]      = ksd_pkg::SC_EXT_DELETE;
    ext_keys[ksd_pkg::CFG_PAGE_UP]     = ksd_pkg::SC_EXT_PGUP;
    ext_keys[ksd_pkg::CFG_PAGE_DOWN]   = ksd_pkg::SC_EXT_PGDN;
    shift_q  = 1'b0;
    ctrl_q   = 1'b0;
    prefix_q = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty read, both shifts, ctrl letters, extended keys,
    // doubled prefix, dropped extended code, ignored break, zero chars
    queue_word(ACT_READ, 8'hFF);
    queue_word(ACT_SCAN, 8'h1E);
    queue_word(ACT_SCAN, ksd_pkg::SC_LSHIFT);
    queue_word(ACT_SCAN, 8'h02);
    queue_word(ACT_SCAN, ksd_pkg::SC_LSHIFT_BRK);
    queue_word(ACT_SCAN, ksd_pkg::SC_RSHIFT);
    queue_word(ACT_SCAN, 8'h1E);
    queue_word(ACT_SCAN, ksd_pkg::SC_RSHIFT_BRK);
    queue_word(ACT_SCAN, ksd_pkg::SC_CTRL);
    queue_word(ACT_SCAN, 8'h2C);
    queue_word(ACT_SCAN, ksd_pkg::SC_CTRL_BRK);
    queue_word(ACT_SCAN, ksd_pkg::SC_PREFIX);
    queue_word(ACT_SCAN, ksd_pkg::SC_EXT_UP);
    queue_word(ACT_SCAN, ksd_pkg::SC_PREFIX);
    queue_word(ACT_SCAN, ksd_pkg::SC_PREFIX);
    queue_word(ACT_SCAN, ksd_pkg::SC_EXT_DOWN);
    queue_word(ACT_SCAN, ksd_pkg::SC_PREFIX);
    queue_word(ACT_SCAN, 8'h1E);
    queue_word(ACT_SCAN, 8'h9E);
    queue_word(ACT_SCAN, 8'h00);
    queue_word(ACT_SCAN, 8'h7F);
    repeat (4) queue_word(ACT_READ, 8'h00);
    wait_idle();

    // Random phases across code settings, extremes included
    program_key_codes(SET_ZERO);
    queue_random_phase(380, 1'b0);
    wait_idle();
    program_key_codes(SET_FULL);
    queue_random_phase(380, 1'b1);
    wait_idle();
    program_key_codes(SET_RANDOM);
    queue_random_phase(380, 1'b1);
    wait_idle();
    program_key_codes(SET_RANDOM);
    queue_random_phase(380, 1'b0);
    wait_idle();
    program_key_codes(SET_DEFAULT);
    queue_random_phase(380, 1'b0);
    wait_idle();

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: keyboard_scancode_decoder_fifo_top.f
hdl/ksd_pkg.sv
hdl/ksd_if.sv
hdl/ksd_front.sv
hdl/ksd_opq.sv
hdl/ksd_back.sv
hdl/keyboard_scancode_decoder_fifo_top.sv
hdl/ksd_checker.sv
bench/keyboard_scancode_decoder_fifo_top_tb.sv
